@@ rtl/psd_pkg.sv @@
// shared widths, types and helpers of the point to segment distance unit
`default_nettype none
package psd_pkg;

   localparam int CoordW = 32;           // coordinate width
   localparam int DiffW  = CoordW + 1;   // coordinate difference
   localparam int ProdW  = 2 * CoordW;   // one product of magnitudes
   localparam int SumW   = ProdW + 2;    // sum of three products
   localparam int QuoW   = CoordW;       // quotient bits of the divider
   localparam int ChunkW = SumW / 3;     // slice of the projection numerator multiply
   localparam int PartW  = ChunkW + CoordW;
   localparam int NumW   = SumW + CoordW;
   localparam int RootW  = CoordW + 3;   // root bits before saturation
   localparam int TrialW = SumW + 5;
   localparam int Dims   = 3;

   localparam logic [1:0] DIM_2D = 2'd2;

   typedef logic [CoordW-1:0] coord_type;
   typedef logic [DiffW-1:0]  diff_type;

   typedef enum logic [1:0] {
      REGION_INTERIOR = 2'd0,
      REGION_START    = 2'd1,
      REGION_END      = 2'd2
   } region_type;

   typedef struct packed {
      region_type              region;
      coord_type [Dims-1:0]    st;
      coord_type [Dims-1:0]    en;
      coord_type [Dims-1:0]    pt;
      logic [Dims-1:0]         s_neg;
   } div_side_type;

   typedef struct packed {
      region_type              region;
      coord_type [Dims-1:0]    proj;
   } dist_side_type;

   // magnitude of a two's complement difference, always fits the coordinate width
   function automatic coord_type mag_of(input diff_type v);
      diff_type n;
      n = v[DiffW-1] ? (~v + DiffW'(1)) : v;
      return n[CoordW-1:0];
   endfunction

endpackage
`default_nettype wire

@@ rtl/psd_req_if.sv @@
// query channel: point and segment endpoints
`default_nettype none
interface psd_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] point_x;
   logic signed [31:0] point_y;
   logic signed [31:0] point_z;
   logic signed [31:0] start_x;
   logic signed [31:0] start_y;
   logic signed [31:0] start_z;
   logic signed [31:0] end_x;
   logic signed [31:0] end_y;
   logic signed [31:0] end_z;

   modport source (
      output valid, point_x, point_y, point_z, start_x, start_y, start_z,
             end_x, end_y, end_z,
      input  ready
   );
   modport sink (
      input  valid, point_x, point_y, point_z, start_x, start_y, start_z,
             end_x, end_y, end_z,
      output ready
   );
endinterface
`default_nettype wire

@@ rtl/psd_rsp_if.sv @@
// result channel: distance, region and nearest point
`default_nettype none
interface psd_rsp_if;
   logic               valid;
   logic               ready;
   logic        [31:0] distance;
   logic        [1:0]  region;
   logic signed [31:0] proj_x;
   logic signed [31:0] proj_y;
   logic signed [31:0] proj_z;

   modport source (
      output valid, distance, region, proj_x, proj_y, proj_z,
      input  ready
   );
   modport sink (
      input  valid, distance, region, proj_x, proj_y, proj_z,
      output ready
   );
endinterface
`default_nettype wire

@@ rtl/point_segment_distance_unit.sv @@
// top level of the point to segment distance unit
// Takes one transaction per clock unless stalled, passing it through six
// stages of dot products and region decision, a 33-stage divider for the
// projection (one quotient bit per stage plus rounding), three stages for the
// nearest point and squared distance, a 35-stage square root (one root bit per
// stage) and the output register. When the output register holds a result that
// is not taken, the whole pipeline holds and req_if.ready drops. The dimension
// register selects 2-D with the value 2; z inputs are then treated as zero.
`default_nettype none
module point_segment_distance_unit import psd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   psd_req_if.sink       req_if,
   psd_rsp_if.source     rsp_if,
   input  logic          csr_wr_en,
   input  logic [1:0]    csr_wr_data
);

   logic [1:0]            dim_val_ff;
   logic                  adv;
   logic                  is_2d;
   coord_type [Dims-1:0]  pt_in, st_in, en_in;

   logic                        front_valid;
   logic [Dims-1:0][NumW-1:0]   front_num;
   logic [SumW-1:0]             front_ss;
   div_side_type                front_side;

   logic                  div_valid;
   coord_type [Dims-1:0]  div_off;
   div_side_type          div_side;

   logic                  dist_valid;
   logic [CoordW-1:0]     dist_value;
   dist_side_type         dist_side;

   logic                  out_valid_ff;
   logic [CoordW-1:0]     distance_ff;
   region_type            region_ff;
   coord_type [Dims-1:0]  proj_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_val_ff <= 2'd3;
      end else if (csr_wr_en) begin
         dim_val_ff <= csr_wr_data;
      end
   end

   assign is_2d = dim_val_ff == DIM_2D;
   assign adv   = !out_valid_ff || rsp_if.ready;

   assign pt_in[0] = req_if.point_x;
   assign pt_in[1] = req_if.point_y;
   assign pt_in[2] = is_2d ? '0 : req_if.point_z;
   assign st_in[0] = req_if.start_x;
   assign st_in[1] = req_if.start_y;
   assign st_in[2] = is_2d ? '0 : req_if.start_z;
   assign en_in[0] = req_if.end_x;
   assign en_in[1] = req_if.end_y;
   assign en_in[2] = is_2d ? '0 : req_if.end_z;

   assign req_if.ready = adv;

   psd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_if.valid),
      .pt_in     (pt_in),
      .st_in     (st_in),
      .en_in     (en_in),
      .out_valid (front_valid),
      .num_out   (front_num),
      .ss_out    (front_ss),
      .side_out  (front_side)
   );

   psd_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (front_valid),
      .num_in    (front_num),
      .ss_in     (front_ss),
      .side_in   (front_side),
      .out_valid (div_valid),
      .off_out   (div_off),
      .side_out  (div_side)
   );

   psd_dist u_dist (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (div_valid),
      .off_in    (div_off),
      .side_in   (div_side),
      .out_valid (dist_valid),
      .distance  (dist_value),
      .side_out  (dist_side)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= dist_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         distance_ff <= dist_value;
         region_ff   <= dist_side.region;
         proj_ff     <= dist_side.proj;
      end
   end

   assign rsp_if.valid    = out_valid_ff;
   assign rsp_if.distance = distance_ff;
   assign rsp_if.region   = region_ff;
   assign rsp_if.proj_x   = proj_ff[0];
   assign rsp_if.proj_y   = proj_ff[1];
   // z is already zero in 2-D since the z inputs were cleared at entry
   assign rsp_if.proj_z   = proj_ff[2];

endmodule
`default_nettype wire

@@ rtl/psd_front.sv @@
// dot products, region decision and projection numerators, six stages
`default_nettype none
module psd_front import psd_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        in_valid,
   input  coord_type [Dims-1:0]        pt_in,
   input  coord_type [Dims-1:0]        st_in,
   input  coord_type [Dims-1:0]        en_in,
   output logic                        out_valid,
   output logic [Dims-1:0][NumW-1:0]   num_out,
   output logic [SumW-1:0]             ss_out,
   output div_side_type                side_out
);

   // stage a: differences
   logic                    a_valid_ff;
   diff_type [Dims-1:0]     s_a_ff, p_a_ff;
   coord_type [Dims-1:0]    st_a_ff, en_a_ff, pt_a_ff;
   logic [Dims-1:0]         s_neg_a;
   // stage b: products
   logic                          b_valid_ff;
   logic [Dims-1:0][ProdW-1:0]    sp_b_ff, ss_b_ff;
   logic [Dims-1:0]               neg_b_ff;
   coord_type [Dims-1:0]          sm_b_ff;
   div_side_type                  side_b_ff;
   // stage c: sums
   logic                    c_valid_ff;
   logic [SumW-1:0]         sp_pos_c_ff, sp_neg_c_ff, ss_c_ff;
   coord_type [Dims-1:0]    sm_c_ff;
   div_side_type            side_c_ff;
   logic [SumW-1:0]         sp_pos_in, sp_neg_in, ss_in;
   // stage d: region
   logic                    d_valid_ff;
   logic [SumW-1:0]         spm_d_ff, ss_d_ff;
   coord_type [Dims-1:0]    sm_d_ff;
   div_side_type            side_d_ff;
   region_type              region_in;
   logic [SumW:0]           end_lhs;
   // stage e: partial products
   logic                                   e_valid_ff;
   logic [Dims-1:0][2:0][PartW-1:0]        pp_e_ff;
   logic [SumW-1:0]                        ss_e_ff;
   div_side_type                           side_e_ff;
   // stage f: numerators
   logic                          f_valid_ff;
   logic [Dims-1:0][NumW-1:0]     num_f_ff;
   logic [SumW-1:0]               ss_f_ff;
   div_side_type                  side_f_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= d_valid_ff;
         f_valid_ff <= e_valid_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < Dims; i++) begin
         s_neg_a[i] = s_a_ff[i][DiffW-1];
      end
   end

   always_comb begin
      sp_pos_in = '0;
      sp_neg_in = '0;
      ss_in     = '0;
      for (int i = 0; i < Dims; i++) begin
         if (neg_b_ff[i]) begin
            sp_neg_in = sp_neg_in + SumW'(sp_b_ff[i]);
         end else begin
            sp_pos_in = sp_pos_in + SumW'(sp_b_ff[i]);
         end
         ss_in = ss_in + SumW'(ss_b_ff[i]);
      end
   end

   assign end_lhs = {1'b0, ss_c_ff} + {1'b0, sp_neg_c_ff};

   always_comb begin
      if (sp_pos_c_ff <= sp_neg_c_ff) begin
         region_in = REGION_START;
      end else if (end_lhs <= {1'b0, sp_pos_c_ff}) begin
         region_in = REGION_END;
      end else begin
         region_in = REGION_INTERIOR;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < Dims; i++) begin
            s_a_ff[i] <= {en_in[i][CoordW-1], en_in[i]} - {st_in[i][CoordW-1], st_in[i]};
            p_a_ff[i] <= {pt_in[i][CoordW-1], pt_in[i]} - {st_in[i][CoordW-1], st_in[i]};
         end
         st_a_ff <= st_in;
         en_a_ff <= en_in;
         pt_a_ff <= pt_in;

         for (int i = 0; i < Dims; i++) begin
            sp_b_ff[i]  <= ProdW'(mag_of(s_a_ff[i])) * ProdW'(mag_of(p_a_ff[i]));
            ss_b_ff[i]  <= ProdW'(mag_of(s_a_ff[i])) * ProdW'(mag_of(s_a_ff[i]));
            neg_b_ff[i] <= s_a_ff[i][DiffW-1] ^ p_a_ff[i][DiffW-1];
            sm_b_ff[i]  <= mag_of(s_a_ff[i]);
         end
         side_b_ff <= '{region: REGION_INTERIOR, st: st_a_ff, en: en_a_ff, pt: pt_a_ff,
                        s_neg: s_neg_a};

         sp_pos_c_ff <= sp_pos_in;
         sp_neg_c_ff <= sp_neg_in;
         ss_c_ff     <= ss_in;
         sm_c_ff     <= sm_b_ff;
         side_c_ff   <= side_b_ff;

         spm_d_ff <= sp_pos_c_ff - sp_neg_c_ff;
         ss_d_ff  <= ss_c_ff;
         sm_d_ff  <= sm_c_ff;
         side_d_ff <= '{region: region_in, st: side_c_ff.st, en: side_c_ff.en,
                        pt: side_c_ff.pt, s_neg: side_c_ff.s_neg};

         // numerator spm * |s| cut into three narrow multiplies
         for (int i = 0; i < Dims; i++) begin
            for (int k = 0; k < 3; k++) begin
               pp_e_ff[i][k] <= PartW'(spm_d_ff[k*ChunkW +: ChunkW]) * PartW'(sm_d_ff[i]);
            end
         end
         ss_e_ff   <= ss_d_ff;
         side_e_ff <= side_d_ff;

         for (int i = 0; i < Dims; i++) begin
            num_f_ff[i] <= NumW'(pp_e_ff[i][0])
                         + (NumW'(pp_e_ff[i][1]) << ChunkW)
                         + (NumW'(pp_e_ff[i][2]) << (2 * ChunkW));
         end
         ss_f_ff   <= ss_e_ff;
         side_f_ff <= side_e_ff;
      end
   end

   assign out_valid = f_valid_ff;
   assign num_out   = num_f_ff;
   assign ss_out    = ss_f_ff;
   assign side_out  = side_f_ff;

endmodule
`default_nettype wire

@@ rtl/psd_div.sv @@
// pipelined restoring divider, one quotient bit per stage, rounded, three lanes
`default_nettype none
module psd_div import psd_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        in_valid,
   input  logic [Dims-1:0][NumW-1:0]   num_in,
   input  logic [SumW-1:0]             ss_in,
   input  div_side_type                side_in,
   output logic                        out_valid,
   output coord_type [Dims-1:0]        off_out,
   output div_side_type                side_out
);

   logic                          valid_ff [QuoW];
   logic [Dims-1:0][SumW-1:0]     rem_ff   [QuoW];
   logic [Dims-1:0][QuoW-1:0]     q_ff     [QuoW];
   logic [Dims-1:0][QuoW-1:0]     lo_ff    [QuoW];
   logic [SumW-1:0]               ss_ff    [QuoW];
   div_side_type                  side_ff  [QuoW];

   logic                          rnd_valid_ff;
   coord_type [Dims-1:0]          off_ff;
   div_side_type                  rnd_side_ff;

   genvar k;
   for (k = 0; k < QuoW; k++) begin : g_stage
      logic                          src_valid;
      logic [Dims-1:0][SumW-1:0]     rem_src;
      logic [Dims-1:0][QuoW-1:0]     q_src, lo_src;
      logic [SumW-1:0]               ss_src;
      div_side_type                  side_src;
      logic [Dims-1:0][SumW:0]       trial;
      logic [Dims-1:0][SumW-1:0]     rem_in;
      logic [Dims-1:0]               bit_in;

      if (k == 0) begin : g_first
         assign src_valid = in_valid;
         assign ss_src    = ss_in;
         assign side_src  = side_in;
         always_comb begin
            for (int i = 0; i < Dims; i++) begin
               rem_src[i] = num_in[i][NumW-1:QuoW];
               lo_src[i]  = num_in[i][QuoW-1:0];
               q_src[i]   = '0;
            end
         end
      end else begin : g_rest
         assign src_valid = valid_ff[k-1];
         assign rem_src   = rem_ff[k-1];
         assign q_src     = q_ff[k-1];
         assign lo_src    = lo_ff[k-1];
         assign ss_src    = ss_ff[k-1];
         assign side_src  = side_ff[k-1];
      end

      always_comb begin
         for (int i = 0; i < Dims; i++) begin
            trial[i] = {rem_src[i], lo_src[i][QuoW-1-k]};
            if (trial[i] >= {1'b0, ss_src}) begin
               rem_in[i] = SumW'(trial[i] - {1'b0, ss_src});
               bit_in[i] = 1'b1;
            end else begin
               rem_in[i] = trial[i][SumW-1:0];
               bit_in[i] = 1'b0;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            for (int i = 0; i < Dims; i++) begin
               rem_ff[k][i] <= rem_in[i];
               q_ff[k][i]   <= {q_src[i][QuoW-2:0], bit_in[i]};
            end
            lo_ff[k]   <= lo_src;
            ss_ff[k]   <= ss_src;
            side_ff[k] <= side_src;
         end
      end
   end

   // round half away from zero on the magnitude
   always_ff @(posedge clock) begin
      if (reset) begin
         rnd_valid_ff <= 1'b0;
      end else if (adv) begin
         rnd_valid_ff <= valid_ff[QuoW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < Dims; i++) begin
            if ({rem_ff[QuoW-1][i], 1'b0} >= {1'b0, ss_ff[QuoW-1]}) begin
               off_ff[i] <= q_ff[QuoW-1][i] + QuoW'(1);
            end else begin
               off_ff[i] <= q_ff[QuoW-1][i];
            end
         end
         rnd_side_ff <= side_ff[QuoW-1];
      end
   end

   assign out_valid = rnd_valid_ff;
   assign off_out   = off_ff;
   assign side_out  = rnd_side_ff;

endmodule
`default_nettype wire

@@ rtl/psd_dist.sv @@
// nearest point, squared distance and pipelined square root with saturation
`default_nettype none
module psd_dist import psd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  coord_type [Dims-1:0]  off_in,
   input  div_side_type          side_in,
   output logic                  out_valid,
   output logic [CoordW-1:0]     distance,
   output dist_side_type         side_out
);

   // stage g: nearest point
   logic                    g_valid_ff;
   coord_type [Dims-1:0]    proj_g_ff, pt_g_ff;
   region_type              region_g_ff;
   // stage h: squares
   logic                          h_valid_ff;
   logic [Dims-1:0][ProdW-1:0]    sq_h_ff;
   dist_side_type                 side_h_ff;
   // stage i: sum
   logic                    i_valid_ff;
   logic [SumW-1:0]         sum_i_ff;
   dist_side_type           side_i_ff;
   // root stages
   logic                    r_valid_ff [RootW];
   logic [RootW-1:0]        root_ff    [RootW];
   logic [SumW-1:0]         rem_ff     [RootW];
   dist_side_type           r_side_ff  [RootW];

   always_ff @(posedge clock) begin
      if (reset) begin
         g_valid_ff <= 1'b0;
         h_valid_ff <= 1'b0;
         i_valid_ff <= 1'b0;
      end else if (adv) begin
         g_valid_ff <= in_valid;
         h_valid_ff <= g_valid_ff;
         i_valid_ff <= h_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < Dims; i++) begin
            case (side_in.region)
               REGION_START: proj_g_ff[i] <= side_in.st[i];
               REGION_END:   proj_g_ff[i] <= side_in.en[i];
               default: begin
                  if (side_in.s_neg[i]) begin
                     proj_g_ff[i] <= side_in.st[i] - off_in[i];
                  end else begin
                     proj_g_ff[i] <= side_in.st[i] + off_in[i];
                  end
               end
            endcase
         end
         pt_g_ff     <= side_in.pt;
         region_g_ff <= side_in.region;

         for (int i = 0; i < Dims; i++) begin
            sq_h_ff[i] <= ProdW'(mag_of({proj_g_ff[i][CoordW-1], proj_g_ff[i]}
                                      - {pt_g_ff[i][CoordW-1], pt_g_ff[i]}))
                        * ProdW'(mag_of({proj_g_ff[i][CoordW-1], proj_g_ff[i]}
                                      - {pt_g_ff[i][CoordW-1], pt_g_ff[i]}));
         end
         side_h_ff <= '{region: region_g_ff, proj: proj_g_ff};

         sum_i_ff  <= SumW'(sq_h_ff[0]) + SumW'(sq_h_ff[1]) + SumW'(sq_h_ff[2]);
         side_i_ff <= side_h_ff;
      end
   end

   genvar j;
   for (j = 0; j < RootW; j++) begin : g_root
      localparam int Bit = RootW - 1 - j;
      logic                src_valid;
      logic [RootW-1:0]    root_src;
      logic [SumW-1:0]     rem_src;
      dist_side_type       side_src;
      logic [TrialW-1:0]   trial;
      logic                take;

      if (j == 0) begin : g_first
         assign src_valid = i_valid_ff;
         assign root_src  = '0;
         assign rem_src   = sum_i_ff;
         assign side_src  = side_i_ff;
      end else begin : g_rest
         assign src_valid = r_valid_ff[j-1];
         assign root_src  = root_ff[j-1];
         assign rem_src   = rem_ff[j-1];
         assign side_src  = r_side_ff[j-1];
      end

      // (r + 2^b)^2 - r^2 against what is left of the radicand
      assign trial = (TrialW'(root_src) << (Bit + 1)) | (TrialW'(1) << (2 * Bit));
      assign take  = trial <= TrialW'(rem_src);

      always_ff @(posedge clock) begin
         if (reset) begin
            r_valid_ff[j] <= 1'b0;
         end else if (adv) begin
            r_valid_ff[j] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            if (take) begin
               rem_ff[j]  <= SumW'(TrialW'(rem_src) - trial);
               root_ff[j] <= root_src | (RootW'(1) << Bit);
            end else begin
               rem_ff[j]  <= rem_src;
               root_ff[j] <= root_src;
            end
            r_side_ff[j] <= side_src;
         end
      end
   end

   assign out_valid = r_valid_ff[RootW-1];
   assign distance  = (root_ff[RootW-1][RootW-1:CoordW] != '0) ? '1
                    : root_ff[RootW-1][CoordW-1:0];
   assign side_out  = r_side_ff[RootW-1];

endmodule
`default_nettype wire

@@ rtl/psd_checker.sv @@
// port-level checks of the distance unit and their binding
`default_nettype none
module psd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_distance,
   input logic [1:0]  rsp_region
);

   // full output register that is not taken freezes the intake
   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("intake open while result is stalled");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_region_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_region != 2'd3)
      else $error("unused region code");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_distance)
                                 && $stable(rsp_region))
      else $error("stalled transaction changed");

endmodule

bind point_segment_distance_unit psd_checker u_psd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_if.ready),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .rsp_distance (rsp_if.distance),
   .rsp_region   (rsp_if.region)
);
`default_nettype wire

@@ test/point_segment_distance_unit_tb.sv @@
// self-checking testbench of the point to segment distance unit
`timescale 1ns / 100ps
`default_nettype none
module point_segment_distance_unit_tb;
   import psd_pkg::*;

   typedef struct {
      logic [31:0] px, py, pz, sx, sy, sz, ex, ey, ez;
   } query_type;

   typedef struct {
      logic [31:0] distance;
      region_type  region;
      logic [31:0] proj_x, proj_y, proj_z;
   } answer_type;

   typedef struct {
      query_type  q;
      bit         typed;
      answer_type a;
   } row_type;

   localparam int CycleLimit = 400000;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [1:0] csr_wr_data;

   psd_req_if req_if ();
   psd_rsp_if rsp_if ();

   point_segment_distance_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if.sink),
      .rsp_if      (rsp_if.source),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   logic [1:0]  dimension_model;
   answer_type  answers_due[$];
   int          errors;
   int          checked;
   int          interior_seen;
   int          cycles;
   bit          quiet;
   int          hold_requests;
   int          hold_served;
   int          hold_left;
   int          stall_left;
   row_type     directed_rows[$];

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // nearest point, region and distance of one query under the current dimension
   function automatic answer_type nearest_on_segment(query_type q, logic [1:0] dimension);
      logic signed [31:0] pt[3], st[3], en[3];
      logic signed [32:0] s, p;
      logic signed [71:0] se, pe, sp, ss, acc;
      logic signed [33:0] pr[3];
      logic signed [33:0] d;
      logic [143:0] num, den, quo, rem;
      logic [71:0] root, trial;
      int dims;
      answer_type a;
      pt = '{q.px, q.py, q.pz};
      st = '{q.sx, q.sy, q.sz};
      en = '{q.ex, q.ey, q.ez};
      dims = (dimension == DIM_2D) ? 2 : 3;
      sp = 0;
      ss = 0;
      for (int i = 0; i < 3; i++) pr[i] = 0;
      for (int i = 0; i < dims; i++) begin
         s = en[i] - st[i];
         p = pt[i] - st[i];
         se = s;
         pe = p;
         sp = sp + se * pe;
         ss = ss + se * se;
      end
      if (sp <= 0) begin
         a.region = REGION_START;
         for (int i = 0; i < dims; i++) pr[i] = st[i];
      end else if (ss <= sp) begin
         a.region = REGION_END;
         for (int i = 0; i < dims; i++) pr[i] = en[i];
      end else begin
         a.region = REGION_INTERIOR;
         for (int i = 0; i < dims; i++) begin
            s = en[i] - st[i];
            se = s;
            if (se < 0) se = -se;
            num = 144'(sp) * 144'(se);
            den = 144'(ss);
            quo = num / den;
            rem = num % den;
            // round half away from zero on the magnitude
            if ((rem << 1) >= den) quo = quo + 1;
            pr[i] = (s < 0) ? (34'(st[i]) - 34'(quo)) : (34'(st[i]) + 34'(quo));
         end
      end
      acc = 0;
      for (int i = 0; i < dims; i++) begin
         d = pr[i] - 34'(pt[i]);
         acc = acc + 72'(d) * 72'(d);
      end
      root = 0;
      for (int b = 34; b >= 0; b--) begin
         trial = root | (72'(1) << b);
         if (trial * trial <= 72'(acc)) root = trial;
      end
      a.distance = (root > 72'hFFFF_FFFF) ? 32'hFFFF_FFFF : root[31:0];
      a.proj_x = pr[0][31:0];
      a.proj_y = pr[1][31:0];
      a.proj_z = pr[2][31:0];
      return a;
   endfunction

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CycleLimit) begin
            $display("%0t timeout with %0d results outstanding", $time, answers_due.size());
            $display("FAIL");
            $finish;
         end
      end
   end

   // result side: random stalls, long hold-offs on request, and checking
   always @(posedge clock) begin
      answer_type e;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left <= 0;
         hold_left <= 0;
         hold_served <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (answers_due.size() == 0) begin
               $display("%0t unexpected transaction: distance %h region %0d", $time,
                        rsp_if.distance, rsp_if.region);
               errors++;
            end else begin
               e = answers_due.pop_front();
               checked++;
               if (e.region == REGION_INTERIOR) interior_seen++;
               if (rsp_if.distance !== e.distance) begin
                  $display("%0t distance exp %h got %h", $time, e.distance, rsp_if.distance);
                  errors++;
               end
               if (rsp_if.region !== e.region) begin
                  $display("%0t region exp %0d got %0d", $time, e.region, rsp_if.region);
                  errors++;
               end
               if (rsp_if.proj_x !== e.proj_x) begin
                  $display("%0t proj_x exp %h got %h", $time, e.proj_x, rsp_if.proj_x);
                  errors++;
               end
               if (rsp_if.proj_y !== e.proj_y) begin
                  $display("%0t proj_y exp %h got %h", $time, e.proj_y, rsp_if.proj_y);
                  errors++;
               end
               if (rsp_if.proj_z !== e.proj_z) begin
                  $display("%0t proj_z exp %h got %h", $time, e.proj_z, rsp_if.proj_z);
                  errors++;
               end
            end
         end
         if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left <= 200;
            rsp_if.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_if.ready <= 1'b0;
         end else if (quiet) begin
            rsp_if.ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_if.ready <= 1'b0;
         end else if ($urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 6);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   task automatic send_query(query_type q, bit typed, answer_type a, bit gaps);
      int gap;
      answer_type expected;
      req_if.valid <= 1'b1;
      req_if.point_x <= q.px;
      req_if.point_y <= q.py;
      req_if.point_z <= q.pz;
      req_if.start_x <= q.sx;
      req_if.start_y <= q.sy;
      req_if.start_z <= q.sz;
      req_if.end_x <= q.ex;
      req_if.end_y <= q.ey;
      req_if.end_z <= q.ez;
      do @(posedge clock); while (!req_if.ready);
      expected = typed ? a : nearest_on_segment(q, dimension_model);
      // in 2-D the nearest point has no z
      if (typed && dimension_model == DIM_2D) expected.proj_z = '0;
      answers_due = {answers_due, expected};
      if (gaps && !quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 7);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_dimension(logic [1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      dimension_model = value;
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_coord(int style, logic [31:0] base);
      case (style)
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 32'h1F_FFFF)) - 32'sh10_0000);
         default: return base + 32'($signed($urandom_range(0, 8191)) - 4096);
      endcase
   endfunction

   function automatic query_type random_query();
      query_type q;
      int style;
      style = $urandom_range(0, 9);
      style = (style < 3) ? 0 : (style < 6) ? 1 : 2;
      q.sx = pick_coord(style == 0 ? 0 : 1, 0);
      q.sy = pick_coord(style == 0 ? 0 : 1, 0);
      q.sz = pick_coord(style == 0 ? 0 : 1, 0);
      q.ex = pick_coord(style == 0 ? 0 : 1, 0);
      q.ey = pick_coord(style == 0 ? 0 : 1, 0);
      q.ez = pick_coord(style == 0 ? 0 : 1, 0);
      if (style == 2) begin
         // point near the segment middle, mostly an interior projection
         q.px = pick_coord(2, ($signed(q.sx) >>> 1) + ($signed(q.ex) >>> 1));
         q.py = pick_coord(2, ($signed(q.sy) >>> 1) + ($signed(q.ey) >>> 1));
         q.pz = pick_coord(2, ($signed(q.sz) >>> 1) + ($signed(q.ez) >>> 1));
      end else begin
         q.px = pick_coord(style, 0);
         q.py = pick_coord(style, 0);
         q.pz = pick_coord(style, 0);
      end
      if ($urandom_range(0, 30) == 0) begin
         q.ex = q.sx;
         q.ey = q.sy;
         q.ez = q.sz;
      end
      return q;
   endfunction

   function automatic row_type make_row(logic [31:0] v[9], bit typed, logic [31:0] span,
                                        region_type region, logic [31:0] x, logic [31:0] y,
                                        logic [31:0] z);
      row_type r;
      r.q = '{v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]};
      r.typed = typed;
      r.a = '{span, region, x, y, z};
      return r;
   endfunction

   initial begin
      localparam logic [31:0] MaxC = 32'h7FFF_FFFF;
      localparam logic [31:0] MinC = 32'h8000_0000;
      localparam logic [31:0] One = 32'h0001_0000;
      logic [1:0] phase_dims[5];
      answer_type none;
      none = '{0, REGION_START, 0, 0, 0};
      errors = 0;
      checked = 0;
      interior_seen = 0;
      quiet = 1'b0;
      hold_requests = 0;
      dimension_model = 2'd3;
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_wr_data <= 2'd0;
      req_if.valid <= 1'b0;
      req_if.point_x <= '0;
      req_if.point_y <= '0;
      req_if.point_z <= '0;
      req_if.start_x <= '0;
      req_if.start_y <= '0;
      req_if.start_z <= '0;
      req_if.end_x <= '0;
      req_if.end_y <= '0;
      req_if.end_z <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // all zero: zero-length segment at the origin
      directed_rows = {directed_rows, make_row('{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, 0,
                                               REGION_START, 0, 0, 0)};
      // opposite corners with a zero-length segment, distance saturates
      directed_rows = {directed_rows, make_row('{MaxC, MaxC, MaxC, MinC, MinC, MinC, MinC,
                                                 MinC, MinC}, 1, 32'hFFFF_FFFF,
                                               REGION_START, MinC, MinC, MinC)};
      directed_rows = {directed_rows, make_row('{MinC, MinC, MinC, MaxC, MaxC, MaxC, MaxC,
                                                 MaxC, MaxC}, 1, 32'hFFFF_FFFF,
                                               REGION_START, MaxC, MaxC, MaxC)};
      // beyond the end of a unit segment on x
      directed_rows = {directed_rows, make_row('{5 * One, 0, 0, 0, 0, 0, One, 0, 0}, 1,
                                               4 * One, REGION_END, One, 0, 0)};
      // behind the start
      directed_rows = {directed_rows, make_row('{-2 * One, 0, 0, 0, 0, 0, One, 0, 0}, 1,
                                               2 * One, REGION_START, 0, 0, 0)};
      // interior, straight above the middle
      directed_rows = {directed_rows, make_row('{5 * One, 3 * One, 0, 0, 0, 0, 10 * One, 0,
                                                 0}, 1, 3 * One, REGION_INTERIOR,
                                               5 * One, 0, 0)};
      // exactly on the start and end points
      directed_rows = {directed_rows, make_row('{7, 8, 9, 7, 8, 9, 70, 80, 90}, 0, 0,
                                               REGION_START, 0, 0, 0)};
      directed_rows = {directed_rows, make_row('{70, 80, 90, 7, 8, 9, 70, 80, 90}, 0, 0,
                                               REGION_END, 0, 0, 0)};
      // projections at the middle of the segment in both directions, and at one third
      directed_rows = {directed_rows, make_row('{1, 5, 0, 0, 0, 0, 2, 0, 0}, 0, 0,
                                               REGION_START, 0, 0, 0)};
      directed_rows = {directed_rows, make_row('{-1, 5, 0, 0, 0, 0, -2, 0, 0}, 0, 0,
                                               REGION_START, 0, 0, 0)};
      directed_rows = {directed_rows, make_row('{1, 1, 1, 0, 0, 0, 3, 3, 3}, 0, 0,
                                               REGION_START, 0, 0, 0)};
      // full-span segments with interior points
      directed_rows = {directed_rows, make_row('{0, 0, 0, MinC, MinC, MinC, MaxC, MaxC,
                                                 MaxC}, 0, 0, REGION_START, 0, 0, 0)};
      directed_rows = {directed_rows, make_row('{MaxC, MinC, 0, MinC, MinC, MinC, MaxC,
                                                 MaxC, MaxC}, 0, 0, REGION_START, 0, 0, 0)};
      directed_rows = {directed_rows, make_row('{MinC, MaxC, MaxC, MinC, MaxC, MinC, MaxC,
                                                 MinC, MaxC}, 0, 0, REGION_START, 0, 0, 0)};
      // z alone decides: start region in 3-D, interior in 2-D
      directed_rows = {directed_rows, make_row('{One, One, -50 * One, 0, 0, 0, 2 * One,
                                                 2 * One, One}, 0, 0, REGION_START,
                                               0, 0, 0)};
      directed_rows = {directed_rows, make_row('{32'hFFFF_FFFF, 32'h5555_5555,
                                                 32'hAAAA_AAAA, 32'h0F0F_0F0F,
                                                 32'hF0F0_F0F0, 0, 32'h1234_5678,
                                                 32'hEDCB_A987, 32'h7FFF_0000}, 0, 0,
                                               REGION_START, 0, 0, 0)};

      phase_dims = '{2'd3, 2'd2, 2'd0, 2'd1, 2'd3};
      for (int phase = 0; phase < 5; phase++) begin
         if (phase > 0) write_dimension(phase_dims[phase]);
         // directed rows under 3-D and 2-D
         if (phase < 2)
            foreach (directed_rows[i])
               send_query(directed_rows[i].q, directed_rows[i].typed, directed_rows[i].a,
                          1'b0);
         if (phase == 1) begin
            // long receiver hold-off while queries keep coming
            hold_requests++;
            for (int n = 0; n < 150; n++) send_query(random_query(), 1'b0, none, 1'b0);
         end
         if (phase == 4) quiet = 1'b1;
         for (int n = 0; n < 230; n++) send_query(random_query(), 1'b0, none, 1'b1);
         drain_results();
      end

      $display("checked %0d results over dimension settings 3, 2, 0, 1, 3", checked);
      $display("%0d interior projections, the rest clamped to an endpoint", interior_seen);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire

@@ sim.f @@
rtl/psd_pkg.sv
rtl/psd_req_if.sv
rtl/psd_rsp_if.sv
rtl/psd_front.sv
rtl/psd_div.sv
rtl/psd_dist.sv
rtl/point_segment_distance_unit.sv
rtl/psd_checker.sv
test/point_segment_distance_unit_tb.sv
